// ===== src/newton_square_root_unit_macros.svh =====
// assertion macros for the newton square root unit
// no dependencies; taken in by the top level
`ifndef NEWTON_SQUARE_ROOT_UNIT_MACROS_SVH
`define NEWTON_SQUARE_ROOT_UNIT_MACROS_SVH

// same-cycle implication, disabled in reset
`define NSR_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define NSR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/nsr_pkg.sv =====
// types, constants and microcode rom for the newton square root unit
// no dependencies
package nsr_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned ROOT_W = 24;
  localparam int unsigned PC_W   = 4;
  localparam int unsigned BCNT_W = 5;

  localparam logic [BCNT_W-1:0] BCNT_LAST = BCNT_W'(DATA_W - 1);
  localparam logic [ROOT_W-1:0] ROOT_MAX  = {ROOT_W{1'b1}};

  // register index of epsilon_threshold
  localparam logic EPS_INDEX = 1'b0;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_ROOT,
    OP_NEXT,
    OP_EMIT_UNCONV,
    OP_EMIT_NEG,
    OP_EMIT_TRIV,
    OP_EMIT_CONV
  } op_t;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NOT_START,
    COND_NEG,
    COND_TRIV,
    COND_DIV_MORE,
    COND_CONV,
    COND_ITER_MORE
  } cond_t;

  typedef struct packed {
    op_t             op;
    cond_t           cond;
    logic [PC_W-1:0] target;
  } ctrl_word_t;

  // step addresses
  localparam logic [PC_W-1:0] A_WAIT        = 4'd0;
  localparam logic [PC_W-1:0] A_CHK_NEG     = 4'd1;
  localparam logic [PC_W-1:0] A_CHK_TRIV    = 4'd2;
  localparam logic [PC_W-1:0] A_DIV_INIT    = 4'd3;
  localparam logic [PC_W-1:0] A_DIV_STEP    = 4'd4;
  localparam logic [PC_W-1:0] A_ROOT        = 4'd5;
  localparam logic [PC_W-1:0] A_CHK_CONV    = 4'd6;
  localparam logic [PC_W-1:0] A_NEXT        = 4'd7;
  localparam logic [PC_W-1:0] A_EMIT_UNCONV = 4'd8;
  localparam logic [PC_W-1:0] A_EMIT_NEG    = 4'd9;
  localparam logic [PC_W-1:0] A_EMIT_TRIV   = 4'd10;
  localparam logic [PC_W-1:0] A_EMIT_CONV   = 4'd11;

  function automatic ctrl_word_t ucode(input logic [PC_W-1:0] pc);
    ctrl_word_t w;
    case (pc)
      A_WAIT:        w = '{OP_LOAD,        COND_NOT_START, A_WAIT};
      A_CHK_NEG:     w = '{OP_NONE,        COND_NEG,       A_EMIT_NEG};
      A_CHK_TRIV:    w = '{OP_NONE,        COND_TRIV,      A_EMIT_TRIV};
      A_DIV_INIT:    w = '{OP_DIV_INIT,    COND_NEVER,     A_WAIT};
      A_DIV_STEP:    w = '{OP_DIV_STEP,    COND_DIV_MORE,  A_DIV_STEP};
      A_ROOT:        w = '{OP_ROOT,        COND_NEVER,     A_WAIT};
      A_CHK_CONV:    w = '{OP_NONE,        COND_CONV,      A_EMIT_CONV};
      A_NEXT:        w = '{OP_NEXT,        COND_ITER_MORE, A_DIV_INIT};
      A_EMIT_UNCONV: w = '{OP_EMIT_UNCONV, COND_ALWAYS,    A_WAIT};
      A_EMIT_NEG:    w = '{OP_EMIT_NEG,    COND_ALWAYS,    A_WAIT};
      A_EMIT_TRIV:   w = '{OP_EMIT_TRIV,   COND_ALWAYS,    A_WAIT};
      A_EMIT_CONV:   w = '{OP_EMIT_CONV,   COND_ALWAYS,    A_WAIT};
      default:       w = '{OP_NONE,        COND_ALWAYS,    A_WAIT};
    endcase
    return w;
  endfunction

endpackage

// ===== src/newton_square_root_unit.sv =====
// newton square root unit: microcoded sequencer around a restoring divider
// depends on nsr_pkg and newton_square_root_unit_macros.svh
`include "newton_square_root_unit_macros.svh"

// Usage
//   An operand is taken on value at a rising edge with start high and busy low.
//   busy stays high while the operand is worked on; one result beat follows,
//   shown for a single cycle with done high on root, invalid and converged.
//   Negative operands give invalid with root zero; zero and one return at once.
//   A negative operand goes from the sign check straight to its result;
//   zero and one go on through the trivial check; otherwise n Newton steps
//   follow (n up to MAX_ITER). Each step is one restoring division of
//   (value << FRAC_BITS) by the estimate plus four control steps. One
//   operand at a time; start may be raised again in the cycle that done
//   is shown.
//   epsilon_threshold sits on the APB port at byte address 0; pready is always high.
//   The user must write it only while the unit is idle; the unit does not check this.
//   Reset (rst, synchronous) returns the sequencer to its wait step, clears
//   done and sets epsilon_threshold to 1.
//   The receiver cannot stall: each result beat must be taken when shown.
module newton_square_root_unit
  import nsr_pkg::*;
#(
  parameter int unsigned MAX_ITER  = 32,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic signed [DATA_W-1:0] value,
  output logic                     done,
  output logic        [ROOT_W-1:0] root,
  output logic                     invalid,
  output logic                     converged,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic        [2:0]        paddr,
  input  logic        [DATA_W-1:0] pwdata,
  output logic        [DATA_W-1:0] prdata,
  output logic                     pready
);

  localparam int unsigned NUM_W  = DATA_W + FRAC_BITS;
  localparam int unsigned ITER_W = $clog2(MAX_ITER + 1);
  localparam logic [DATA_W-1:0] ONE_VAL   = DATA_W'(1) << FRAC_BITS;
  localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(MAX_ITER);

  logic [DATA_W-1:0] eps;
  logic [PC_W-1:0]   pc;
  logic [PC_W-1:0]   pc_next;
  logic [DATA_W-1:0] val;
  logic [DATA_W-1:0] x;
  logic [DATA_W-1:0] est;
  logic [DATA_W-1:0] rem;
  logic [DATA_W-1:0] quo;
  logic [BCNT_W-1:0] bcnt;
  logic [ITER_W-1:0] iter;

  ctrl_word_t        cw;
  logic              take;
  logic [NUM_W-1:0]  num;
  logic [DATA_W-1:0] divisor;
  logic [DATA_W:0]   trial;
  logic              trial_ok;
  logic [DATA_W:0]   sum;
  logic [DATA_W-1:0] diff;
  logic              conv;
  logic [ROOT_W-1:0] est_sat;
  logic [ROOT_W-1:0] one_sat;

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == EPS_INDEX) ? eps : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      eps <= DATA_W'(1);
    end else if (psel && penable && pwrite && pready && paddr[2] == EPS_INDEX) begin
      eps <= pwdata;
    end
  end

  // datapath combinational terms
  assign cw       = ucode(pc);
  assign take     = start && !busy;
  assign busy     = (pc != A_WAIT);
  assign num      = {{FRAC_BITS{1'b0}}, val} << FRAC_BITS;
  assign divisor  = (x != '0) ? x : DATA_W'(1);
  assign trial    = {rem, quo[DATA_W-1]};
  assign trial_ok = (trial >= {1'b0, divisor});
  assign sum      = {1'b0, x} + {1'b0, quo};
  assign diff     = (est >= x) ? (est - x) : (x - est);
  assign conv     = (diff < eps);
  assign est_sat  = (|est[DATA_W-1:ROOT_W]) ? ROOT_MAX : est[ROOT_W-1:0];
  assign one_sat  = (|ONE_VAL[DATA_W-1:ROOT_W]) ? ROOT_MAX : ONE_VAL[ROOT_W-1:0];

  // step counter and conditional jumps
  always_comb begin
    logic jump;
    case (cw.cond)
      COND_NEVER:     jump = 1'b0;
      COND_ALWAYS:    jump = 1'b1;
      COND_NOT_START: jump = !start;
      COND_NEG:       jump = val[DATA_W-1];
      COND_TRIV:      jump = (val == '0) || (val == ONE_VAL);
      COND_DIV_MORE:  jump = (bcnt != BCNT_LAST);
      COND_CONV:      jump = conv;
      COND_ITER_MORE: jump = (iter != ITER_LAST);
      default:        jump = 1'b0;
    endcase
    pc_next = jump ? cw.target : pc + PC_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= A_WAIT;
    end else begin
      pc <= pc_next;
    end
  end

  // datapath registers driven by the control word
  always_ff @(posedge clk) begin
    case (cw.op)
      OP_LOAD: begin
        if (take) begin
          val  <= value;
          x    <= value;
          iter <= '0;
        end
      end
      OP_DIV_INIT: begin
        // high part of the dividend is below the divisor, so 32 quotient bits suffice
        rem  <= DATA_W'(num[NUM_W-1:DATA_W]);
        quo  <= num[DATA_W-1:0];
        bcnt <= '0;
      end
      OP_DIV_STEP: begin
        rem  <= trial_ok ? DATA_W'(trial - {1'b0, divisor}) : trial[DATA_W-1:0];
        quo  <= {quo[DATA_W-2:0], trial_ok};
        bcnt <= bcnt + BCNT_W'(1);
      end
      OP_ROOT: begin
        est  <= sum[DATA_W:1];
        iter <= iter + ITER_W'(1);
      end
      OP_NEXT: begin
        x <= est;
      end
      default: begin
      end
    endcase
  end

  // result beat
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (cw.op == OP_EMIT_UNCONV) || (cw.op == OP_EMIT_NEG) ||
              (cw.op == OP_EMIT_TRIV) || (cw.op == OP_EMIT_CONV);
    end
  end

  always_ff @(posedge clk) begin
    case (cw.op)
      OP_EMIT_UNCONV: begin
        root      <= est_sat;
        invalid   <= 1'b0;
        converged <= 1'b0;
      end
      OP_EMIT_NEG: begin
        root      <= '0;
        invalid   <= 1'b1;
        converged <= 1'b0;
      end
      OP_EMIT_TRIV: begin
        root      <= (val == '0) ? '0 : one_sat;
        invalid   <= 1'b0;
        converged <= 1'b1;
      end
      OP_EMIT_CONV: begin
        root      <= est_sat;
        invalid   <= 1'b0;
        converged <= 1'b1;
      end
      default: begin
      end
    endcase
  end

  `NSR_ASSERT_IMPL(a_done_idle, clk, rst, done, !busy, "result beat while busy")
  `NSR_ASSERT_NEXT(a_take_busy, clk, rst, take, busy, "accepted operand did not raise busy")
  `NSR_ASSERT_IMPL(a_flags_excl, clk, rst, done, !(invalid && converged), "invalid and converged together")
  `NSR_ASSERT_IMPL(a_invalid_zero, clk, rst, done && invalid, root == '0, "invalid result with non-zero root")

endmodule

// ===== verif/tb_newton_square_root_unit.sv =====
// self-checking bench for newton_square_root_unit: directed corners, then random operands
// over several epsilon_threshold settings and sender idling patterns
// depends on nsr_pkg and the newton_square_root_unit rtl
module tb_newton_square_root_unit
  import nsr_pkg::*;
();

  localparam int unsigned NEWTON_STEPS = 32;
  localparam int unsigned FRAC = 16;
  localparam logic [DATA_W-1:0] FIX_ONE = DATA_W'(1) << FRAC;
  localparam logic [2:0] EPS_ADDR = 3'(EPS_INDEX) << 2;
  localparam logic [2:0] SPARE_ADDR = 3'd4;
  localparam int unsigned RANDOM_SEGMENTS = 9;
  localparam int unsigned SEGMENT_OPERANDS = 50;

  typedef struct packed {
    logic [ROOT_W-1:0] root;
    logic              invalid;
    logic              converged;
  } root_beat_t;

  class root_checker;
    logic [DATA_W-1:0] threshold;
    root_beat_t        pending_roots[$];
    int                errors;
    int                roots_checked;
    int                negatives;
    int                unconverged;

    function new();
      threshold = 1;
      errors = 0;
      roots_checked = 0;
      negatives = 0;
      unconverged = 0;
    endfunction

    function root_beat_t newton_root(logic [DATA_W-1:0] operand);
      root_beat_t  beat;
      logic [63:0] raw, num, est, next_est, divisor, change;
      logic        settled;
      raw = {32'd0, operand};
      beat.root = '0;
      beat.invalid = 1'b0;
      beat.converged = 1'b1;
      if (operand[DATA_W-1]) begin
        beat.invalid = 1'b1;
        beat.converged = 1'b0;
      end else if (raw == 0 || raw == {32'd0, FIX_ONE}) begin
        beat.root = raw[ROOT_W-1:0];
      end else begin
        num = raw << FRAC;
        est = raw;
        next_est = raw;
        settled = 1'b0;
        for (int i = 0; i < NEWTON_STEPS && !settled; i++) begin
          divisor = (est != 0) ? est : 64'd1;
          next_est = (est + num / divisor) >> 1;
          change = (next_est >= est) ? next_est - est : est - next_est;
          if (change < {32'd0, threshold}) settled = 1'b1;
          else est = next_est;
        end
        beat.root = (next_est > {40'd0, ROOT_MAX}) ? ROOT_MAX : next_est[ROOT_W-1:0];
        beat.converged = settled;
      end
      return beat;
    endfunction

    function void note_operand(logic [DATA_W-1:0] operand);
      pending_roots.push_back(newton_root(operand));
    endfunction

    function void check_root(logic [ROOT_W-1:0] got_root, logic got_invalid,
                             logic got_converged);
      root_beat_t want;
      if (pending_roots.size() == 0) begin
        $display("%0t: unexpected result beat, root %h invalid %b converged %b",
                 $time, got_root, got_invalid, got_converged);
        errors++;
        return;
      end
      want = pending_roots.pop_front();
      roots_checked++;
      if (want.invalid) negatives++;
      else if (!want.converged) unconverged++;
      if (got_root !== want.root) begin
        $display("%0t: root mismatch, expected %h, got %h", $time, want.root, got_root);
        errors++;
      end
      if (got_invalid !== want.invalid) begin
        $display("%0t: invalid mismatch, expected %b, got %b", $time, want.invalid,
                 got_invalid);
        errors++;
      end
      if (got_converged !== want.converged) begin
        $display("%0t: converged mismatch, expected %b, got %b", $time, want.converged,
                 got_converged);
        errors++;
      end
    endfunction
  endclass

  logic                     clk;
  logic                     rst;
  logic                     start;
  logic                     busy;
  logic signed [DATA_W-1:0] value;
  logic                     done;
  logic        [ROOT_W-1:0] root;
  logic                     invalid;
  logic                     converged;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic        [2:0]        paddr;
  logic        [DATA_W-1:0] pwdata;
  logic        [DATA_W-1:0] prdata;
  logic                     pready;

  root_checker sb;
  int          sender_idle_pct;
  int          operands_sent;
  int          settings_used;

  newton_square_root_unit #(
    .MAX_ITER (NEWTON_STEPS),
    .FRAC_BITS(FRAC)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .value    (value),
    .done     (done),
    .root     (root),
    .invalid  (invalid),
    .converged(converged),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // result beats cannot be held off, so every strobe is checked as it appears
  always @(posedge clk) begin
    if (!rst && done) sb.check_root(root, invalid, converged);
  end

  task automatic send_operand(input logic [DATA_W-1:0] operand);
    int gap;
    gap = 0;
    if ($urandom_range(99) < sender_idle_pct)
      gap = ($urandom_range(3) == 0) ? $urandom_range(600, 20) : $urandom_range(12, 1);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    value <= operand;
    do @(posedge clk); while (busy);
    sb.note_operand(operand);
    operands_sent++;
  endtask

  task automatic write_register(input logic [2:0] addr, input logic [DATA_W-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == EPS_ADDR) begin
      sb.threshold = data;
      settings_used++;
    end
    // return the bus to idle before the next bus transfer
    @(posedge clk);
  endtask

  task automatic read_threshold();
    logic [DATA_W-1:0] got;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= EPS_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    if (got !== sb.threshold) begin
      $display("%0t: threshold readback mismatch, expected %h, got %h", $time,
               sb.threshold, got);
      sb.errors++;
    end
    // return the bus to idle before the next bus transfer
    @(posedge clk);
  endtask

  // stop offering operands and let the last one finish before touching the register
  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending_roots.size() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [DATA_W-1:0] pick_operand();
    int unsigned roll;
    roll = $urandom_range(19);
    if (roll < 3) return $urandom | 32'h8000_0000;
    if (roll == 3) return $urandom_range(1) ? FIX_ONE : '0;
    if (roll < 12) return $urandom_range(32'h0003_FFFF, 1);
    return $urandom & 32'h7FFF_FFFF;
  endfunction

  function automatic logic [DATA_W-1:0] pick_threshold(int unsigned seg);
    case (seg)
      0:       return 32'd1;
      1:       return 32'd2;
      2:       return 32'd0;
      3:       return 32'hFFFF_FFFF;
      4:       return 32'd16;
      5:       return 32'd256;
      6:       return $urandom_range(65536, 1);
      7:       return 32'd1;
      default: return FIX_ONE;
    endcase
  endfunction

  initial begin
    int guard;
    clk = 1'b0;
    rst = 1'b1;
    start = 1'b0;
    value = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    sb = new();
    sender_idle_pct = 34;
    operands_sent = 0;
    settings_used = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset value of the threshold, then corners at the default setting
    read_threshold();
    send_operand(32'h0000_0000);
    send_operand(FIX_ONE);
    send_operand(32'hFFFF_FFFF);
    send_operand(32'h8000_0000);
    send_operand(32'hFFFF_0000);
    send_operand(32'h7FFF_FFFF);
    send_operand(32'h0000_0001);
    send_operand(32'h0000_0002);
    send_operand(32'h0000_FFFF);
    send_operand(32'h0001_0001);
    send_operand(32'h0002_0000);
    send_operand(32'h0009_0000);
    send_operand(32'h4000_0000);
    send_operand(32'h0000_8000);
    wait_idle();

    // zero threshold can never be met
    write_register(EPS_ADDR, 32'd0);
    read_threshold();
    send_operand(32'h0002_0000);
    send_operand(32'h7FFF_FFFF);
    send_operand(32'h0000_0000);
    send_operand(FIX_ONE);
    send_operand(32'h8000_0000);
    wait_idle();

    // widest threshold settles after one step
    write_register(EPS_ADDR, 32'hFFFF_FFFF);
    read_threshold();
    send_operand(32'h0002_0000);
    send_operand(32'h7FFF_FFFF);
    send_operand(32'h0000_0001);
    wait_idle();

    // a write to an unmapped index must leave the threshold alone
    write_register(SPARE_ADDR, 32'h0000_0005);
    read_threshold();

    for (int seg = 0; seg < RANDOM_SEGMENTS; seg++) begin
      case (seg / 3)
        0:       sender_idle_pct = 34;
        1:       sender_idle_pct = 69;
        default: sender_idle_pct = 0;
      endcase
      write_register(EPS_ADDR, pick_threshold(seg));
      read_threshold();
      for (int n = 0; n < SEGMENT_OPERANDS; n++) send_operand(pick_operand());
      wait_idle();
    end

    guard = 0;
    while ((sb.pending_roots.size() != 0 || busy) && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    if (sb.pending_roots.size() != 0) begin
      $display("%0t: %0d result beats never arrived", $time, sb.pending_roots.size());
      sb.errors += sb.pending_roots.size();
    end
    repeat (8) @(posedge clk);

    $display("covered %0d operands over %0d threshold writes: %0d negative, %0d unconverged",
             operands_sent, settings_used, sb.negatives, sb.unconverged);
    $display("%0d result beats checked, %0d errors", sb.roots_checked, sb.errors);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("timeout with %0d result beats outstanding", sb.pending_roots.size());
    $display("TB_ERROR");
    $finish;
  end

endmodule
